// ===== sv/canonical_kmer_extractor_top_assert.svh =====
// ----------------------------------------------------------------------------
// canonical k-mer extractor assertion macros
// shared property forms for the extractor checks
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_EXTRACTOR_TOP_ASSERT_SVH
`define CANONICAL_KMER_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CKE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cke_pkg.sv =====
// ----------------------------------------------------------------------------
// cke_pkg
// types, character codes and base decode for the canonical k-mer extractor
// ----------------------------------------------------------------------------
package cke_pkg;

    // default of MAX_K, the upper bound of the k-mer length
    localparam int unsigned MAX_K_DEF = 32;

    // field and register widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned KMER_W  = 64;
    localparam int unsigned KLEN_W  = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned SHAMT_W = 7;
    localparam int unsigned CODE_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 2'd1;

    // register reset values
    localparam logic [KLEN_W-1:0] KLEN_RST      = 6'd21;
    localparam logic              CANONICAL_RST = 1'b1;

    // special characters
    localparam logic [CHAR_W-1:0] CH_GT = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    // base codes
    localparam logic [CODE_W-1:0] BASE_A     = 3'd0;
    localparam logic [CODE_W-1:0] BASE_C     = 3'd1;
    localparam logic [CODE_W-1:0] BASE_G     = 3'd2;
    localparam logic [CODE_W-1:0] BASE_T     = 3'd3;
    localparam logic [CODE_W-1:0] NOT_A_BASE = 3'd4;

    typedef enum logic [1:0] {
        PM_OUTSIDE  = 2'd0,
        PM_HEADER   = 2'd1,
        PM_SEQUENCE = 2'd2
    } t_parse_mode;

    // map a text byte to its 2-bit base, or flag it as no base
    function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            8'h41, 8'h61: code = BASE_A;
            8'h43, 8'h63: code = BASE_C;
            8'h47, 8'h67: code = BASE_G;
            8'h54, 8'h74,
            8'h55, 8'h75: code = BASE_T;
            default:      code = NOT_A_BASE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/canonical_kmer_extractor_top.sv =====
// path: a byte is taken into the input register and, in one logic pass,
//   its k-mer is written into the output register
// throughput: one byte per cycle while not stalled; the forward/reverse shift
//   and strand compare sit in the single pass from input to result register
// reset: synchronous, active low; parser outside any record, strands and run
//   length cleared, k = 21 and canonical mode on
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_top
// parses a FASTA byte stream and emits one 2-bit packed k-mer per base
// once the current base run holds k bases
// ----------------------------------------------------------------------------
`include "canonical_kmer_extractor_top_assert.svh"

module canonical_kmer_extractor_top #(
    parameter int unsigned MAX_K = cke_pkg::MAX_K_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [cke_pkg::CHAR_W-1:0]         i_char_in,
    // k-mer output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [cke_pkg::KMER_W-1:0]         o_kmer_value,
    output logic                               o_from_reverse,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cke_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cke_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // strand width and run counter width follow from the largest k
    localparam int unsigned W  = 2 * MAX_K;
    localparam int unsigned KW = $clog2(MAX_K + 1);

    // configuration registers
    logic [cke_pkg::KLEN_W-1:0] r_kmer_length;
    logic                       r_canonical;

    // input register (doubles as the skid stage toward the output)
    logic                       r_in_valid;
    logic [cke_pkg::CHAR_W-1:0] r_char;

    // parser and rolling strand state
    cke_pkg::t_parse_mode r_mode, n_mode;
    logic [W-1:0]         r_fwd, n_fwd;
    logic [W-1:0]         r_rev, n_rev;
    logic [KW-1:0]        r_run, n_run;

    // result register
    logic                       r_out_valid;
    logic [cke_pkg::KMER_W-1:0] r_kmer_value;
    logic                       r_from_reverse;

    // per-byte decode
    logic                        is_gt, is_lf, is_cr;
    logic [cke_pkg::CODE_W-1:0]  code;
    logic                        shift_en, run_clr, emit;
    logic                        out_free, fire;

    // strand extraction
    logic [W+1:0]                fwd_ext, rev_ext;
    logic [KW-1:0]               run_inc;
    logic [KW-1:0]               k_eff;
    logic [cke_pkg::SHAMT_W-1:0] k2, rev_shamt;
    logic [W-1:0]                mask, fwd_k, rev_k;
    logic                        pick_rev;

    // ------------------------------------------------------------------
    // handshake: the byte in the input register moves on when the result
    // register is empty or being taken, so unless o_stall is high a new byte can enter every cycle
    // ------------------------------------------------------------------
    assign out_free    = !r_out_valid || !i_stall;
    assign fire        = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    assign o_valid        = r_out_valid;
    assign o_kmer_value   = r_kmer_value;
    assign o_from_reverse = r_from_reverse;

    assign is_gt = (r_char == cke_pkg::CH_GT);
    assign is_lf = (r_char == cke_pkg::CH_LF);
    assign is_cr = (r_char == cke_pkg::CH_CR);
    assign code  = cke_pkg::base_code(r_char);

    // ------------------------------------------------------------------
    // parser next state
    // ------------------------------------------------------------------
    always_comb begin
        n_mode = r_mode;
        if (is_gt && r_mode != cke_pkg::PM_HEADER) begin
            n_mode = cke_pkg::PM_HEADER;
        end else begin
            case (r_mode)
                cke_pkg::PM_HEADER: begin
                    if (is_lf) begin
                        n_mode = cke_pkg::PM_SEQUENCE;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // parser outputs: shift a base in, or break the run
    // ------------------------------------------------------------------
    always_comb begin
        shift_en = 1'b0;
        run_clr  = 1'b0;
        if (is_gt && r_mode != cke_pkg::PM_HEADER) begin
            // a new header always breaks the run
            run_clr = 1'b1;
        end else begin
            case (r_mode)
                cke_pkg::PM_SEQUENCE: begin
                    // line breaks inside a sequence are transparent
                    if (!is_lf && !is_cr) begin
                        if (code == cke_pkg::NOT_A_BASE) begin
                            run_clr = 1'b1;
                        end else begin
                            shift_en = 1'b1;
                        end
                    end
                end
                default: begin
                    shift_en = 1'b0;
                    run_clr  = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // rolling strands: forward takes the newest base in the low bits,
    // reverse complement takes its complement in the high bits
    // ------------------------------------------------------------------
    assign fwd_ext = {r_fwd, code[1:0]};
    assign rev_ext = {~code[1:0], r_rev};
    assign n_fwd   = fwd_ext[W-1:0];
    assign n_rev   = rev_ext[W+1:2];

    // run length saturates at the largest k
    assign run_inc = (r_run < KW'(MAX_K)) ? (r_run + KW'(1)) : r_run;
    assign n_run   = run_clr ? '0 : (shift_en ? run_inc : r_run);

    // k clamps into 1..MAX_K
    always_comb begin
        if (r_kmer_length == '0) begin
            k_eff = KW'(1);
        end else if (r_kmer_length > cke_pkg::KLEN_W'(MAX_K)) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(r_kmer_length);
        end
    end

    // keep the newest k bases of each strand
    assign k2        = cke_pkg::SHAMT_W'({k_eff, 1'b0});
    assign rev_shamt = cke_pkg::SHAMT_W'(W) - k2;
    assign mask      = ~({W{1'b1}} << k2);
    assign fwd_k     = n_fwd & mask;
    assign rev_k     = n_rev >> rev_shamt;

    // on a tie the forward strand wins
    assign pick_rev = r_canonical && (rev_k < fwd_k);
    assign emit     = shift_en && (run_inc >= k_eff);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= cke_pkg::KLEN_RST;
            r_canonical   <= cke_pkg::CANONICAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cke_pkg::CFG_KMER_LENGTH:    r_kmer_length <= i_cfg_data;
                cke_pkg::CFG_CANONICAL_MODE: r_canonical   <= i_cfg_data[0];
                default: begin
                    r_kmer_length <= r_kmer_length;
                    r_canonical   <= r_canonical;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= i_char_in;
        end
    end

    // ------------------------------------------------------------------
    // parser and strand state, updated once per byte
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cke_pkg::PM_OUTSIDE;
            r_fwd  <= '0;
            r_rev  <= '0;
            r_run  <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_run  <= n_run;
            if (shift_en) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_kmer_value   <= cke_pkg::KMER_W'(pick_rev ? rev_k : fwd_k);
            r_from_reverse <= pick_rev;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a k-mer only comes out of a sequence line
    `CKE_ASSERT_NOW(a_emit_in_seq, i_clk, i_rst_n, fire && emit, r_mode == cke_pkg::PM_SEQUENCE, "k-mer emitted outside a sequence")
    // an emitted k-mer lands in the result register on the next edge
    `CKE_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, fire && emit, r_out_valid, "emitted k-mer lost")
    // the reverse strand is only ever chosen in canonical mode
    `CKE_ASSERT_NOW(a_rev_canon, i_clk, i_rst_n, r_out_valid && r_from_reverse, r_canonical, "reverse strand outside canonical mode")
    // a byte that breaks the run never emits
    `CKE_ASSERT_NOW(a_break_quiet, i_clk, i_rst_n, fire && run_clr, !emit && (n_run == '0), "run break emitted a k-mer")

endmodule
